@@ hw/rtl/rme_pkg.sv @@
package rme_pkg;

	localparam int unsigned MOD_BITS = 31;
	localparam int unsigned DATA_BITS = ((MOD_BITS + 7) / 8) * 8;
	localparam int unsigned BIT_W = $clog2(MOD_BITS);
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_MODULUS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PUB_EXP = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PRIV_EXP = 2'd2;

	localparam logic OP_ENCRYPT = 1'b0;
	localparam logic OP_DECRYPT = 1'b1;

	typedef logic [MOD_BITS-1:0] word_t;

	typedef struct packed {
		logic  vld;
		word_t acc;
		word_t a;
		word_t b;
	} cell_bus_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_SQUARE,
		ST_MULT,
		ST_OUT
	} state_t;

endpackage

@@ hw/rtl/rme_cell.sv @@
module rme_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  rme_pkg::word_t      modulus,
	input  rme_pkg::cell_bus_t  din,
	output rme_pkg::cell_bus_t  dout
);

	logic [rme_pkg::MOD_BITS:0] dbl;
	logic [rme_pkg::MOD_BITS:0] sum;
	rme_pkg::word_t             dbl_red;
	rme_pkg::word_t             addend;
	rme_pkg::word_t             sum_red;
	logic                       vld_q;
	rme_pkg::word_t             acc_q;
	rme_pkg::word_t             a_q;
	rme_pkg::word_t             b_q;

	always_comb begin
		dbl = {1'b0, din.acc} + {1'b0, din.acc};
		if (dbl >= {1'b0, modulus}) begin
			dbl = dbl - {1'b0, modulus};
		end
		dbl_red = dbl[rme_pkg::MOD_BITS-1:0];
		addend = din.b[rme_pkg::MOD_BITS-1] ? din.a : '0;
		sum = {1'b0, dbl_red} + {1'b0, addend};
		if (sum >= {1'b0, modulus}) begin
			sum = sum - {1'b0, modulus};
		end
		sum_red = sum[rme_pkg::MOD_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= din.vld;
		end
	end

	always_ff @(posedge clk) begin
		acc_q <= sum_red;
		a_q <= din.a;
		b_q <= {din.b[rme_pkg::MOD_BITS-2:0], 1'b0};
	end

	assign dout = '{vld: vld_q, acc: acc_q, a: a_q, b: b_q};

endmodule

@@ hw/rtl/rme_chain.sv @@
module rme_chain (
	input  logic                clk,
	input  logic                arst_n,
	input  rme_pkg::word_t      modulus,
	input  rme_pkg::cell_bus_t  din,
	output rme_pkg::cell_bus_t  dout
);

	rme_pkg::cell_bus_t link [rme_pkg::MOD_BITS+1];

	assign link[0] = din;

	for (genvar i = 0; i < rme_pkg::MOD_BITS; i++) begin : g_cell
		rme_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.modulus (modulus),
			.din     (link[i]),
			.dout    (link[i+1])
		);
	end

	assign dout = link[rme_pkg::MOD_BITS];

endmodule

@@ hw/rtl/rsa_modular_exponentiation_top.sv @@
// Modular exponentiation value^exp mod modulus by square-and-multiply, one request at a
// time. Each modular product runs through a row of 31 double-and-add cells, one multiplier
// bit per cell: a product is launched, passes the 31 cells in turn and is captured as it
// leaves the row. A request costs one reduction of the base plus one squaring for each of
// the 31 exponent bits and one extra product per set bit. A modulus of 0 or 1 answers 0
// without using the row. Encrypt raises the low byte of value to the public exponent;
// decrypt raises value to the private exponent and returns the low byte. The user must
// write registers only while no request is in flight; the block does not enforce this.
module rsa_modular_exponentiation_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [rme_pkg::DATA_BITS-1:0]   s_tdata,   // value
	input  logic                            s_tuser,   // op
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [rme_pkg::DATA_BITS-1:0]   m_tdata,   // result
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [rme_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  rme_pkg::word_t                  cfg_data
);

	rme_pkg::word_t          modulus_q;
	rme_pkg::word_t          pub_exp_q;
	rme_pkg::word_t          priv_exp_q;
	rme_pkg::state_t         state_q;
	rme_pkg::state_t         state_d;
	logic                    busy_q;
	logic                    busy_d;
	logic                    op_q;
	rme_pkg::word_t          base_q;
	rme_pkg::word_t          acc_q;
	rme_pkg::word_t          acc_d;
	rme_pkg::word_t          exp_q;
	logic [rme_pkg::BIT_W-1:0] bit_q;
	logic [rme_pkg::BIT_W-1:0] bit_d;
	logic                    out_vld_q;
	rme_pkg::word_t          out_q;
	logic                    in_acc;
	logic                    out_load;
	rme_pkg::cell_bus_t      launch;
	rme_pkg::cell_bus_t      chain_out;
	rme_pkg::word_t          in_value;

	assign cfg_ready = 1'b1;
	assign s_tready = (state_q == rme_pkg::ST_IDLE);
	assign in_acc = s_tvalid && s_tready;
	assign in_value = s_tdata[rme_pkg::MOD_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= rme_pkg::MOD_BITS'(2);
			pub_exp_q <= rme_pkg::MOD_BITS'(1);
			priv_exp_q <= rme_pkg::MOD_BITS'(1);
		end else if (cfg_valid) begin
			case (cfg_index)
				rme_pkg::REG_MODULUS:  modulus_q <= cfg_data;
				rme_pkg::REG_PUB_EXP:  pub_exp_q <= cfg_data;
				rme_pkg::REG_PRIV_EXP: priv_exp_q <= cfg_data;
				default: ;
			endcase
		end
	end

	rme_chain u_chain (
		.clk     (clk),
		.arst_n  (arst_n),
		.modulus (modulus_q),
		.din     (launch),
		.dout    (chain_out)
	);

	always_comb begin
		state_d = state_q;
		busy_d = busy_q;
		acc_d = acc_q;
		bit_d = bit_q;
		out_load = 1'b0;
		launch = '{vld: 1'b0, acc: '0, a: acc_q, b: acc_q};
		case (state_q)
			rme_pkg::ST_IDLE: begin
				if (in_acc) begin
					if (modulus_q < rme_pkg::MOD_BITS'(2)) begin
						acc_d = '0;
						state_d = rme_pkg::ST_OUT;
					end else begin
						state_d = rme_pkg::ST_REDUCE;
					end
				end
			end
			rme_pkg::ST_REDUCE: begin
				launch.a = rme_pkg::MOD_BITS'(1);
				launch.b = base_q;
				if (!busy_q) begin
					launch.vld = 1'b1;
					busy_d = 1'b1;
				end else if (chain_out.vld) begin
					busy_d = 1'b0;
					acc_d = rme_pkg::MOD_BITS'(1);
					bit_d = rme_pkg::BIT_W'(rme_pkg::MOD_BITS - 1);
					state_d = rme_pkg::ST_SQUARE;
				end
			end
			rme_pkg::ST_SQUARE: begin
				if (!busy_q) begin
					launch.vld = 1'b1;
					busy_d = 1'b1;
				end else if (chain_out.vld) begin
					busy_d = 1'b0;
					acc_d = chain_out.acc;
					if (exp_q[bit_q]) begin
						state_d = rme_pkg::ST_MULT;
					end else if (bit_q == '0) begin
						state_d = rme_pkg::ST_OUT;
					end else begin
						bit_d = bit_q - 1'b1;
					end
				end
			end
			rme_pkg::ST_MULT: begin
				launch.b = base_q;
				if (!busy_q) begin
					launch.vld = 1'b1;
					busy_d = 1'b1;
				end else if (chain_out.vld) begin
					busy_d = 1'b0;
					acc_d = chain_out.acc;
					if (bit_q == '0) begin
						state_d = rme_pkg::ST_OUT;
					end else begin
						bit_d = bit_q - 1'b1;
						state_d = rme_pkg::ST_SQUARE;
					end
				end
			end
			rme_pkg::ST_OUT: begin
				if (!out_vld_q || m_tready) begin
					out_load = 1'b1;
					state_d = rme_pkg::ST_IDLE;
				end
			end
			default: state_d = rme_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rme_pkg::ST_IDLE;
			busy_q <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			busy_q <= busy_d;
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		acc_q <= acc_d;
		bit_q <= bit_d;
		if (in_acc) begin
			op_q <= s_tuser;
			if (s_tuser == rme_pkg::OP_ENCRYPT) begin
				base_q <= {{(rme_pkg::MOD_BITS-8){1'b0}}, in_value[7:0]};
				exp_q <= pub_exp_q;
			end else begin
				base_q <= in_value;
				exp_q <= priv_exp_q;
			end
		end
		if (out_load) begin
			if (op_q == rme_pkg::OP_DECRYPT) begin
				out_q <= {{(rme_pkg::MOD_BITS-8){1'b0}}, acc_q[7:0]};
			end else begin
				out_q <= acc_q;
			end
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata = {{(rme_pkg::DATA_BITS-rme_pkg::MOD_BITS){1'b0}}, out_q};

endmodule

@@ hw/rtl/rme_checker.sv @@
module rme_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [rme_pkg::DATA_BITS-1:0] m_tdata
);

	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while request in flight");

	a_no_result_early: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
		else $error("result appeared one cycle after request");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[rme_pkg::DATA_BITS-1:rme_pkg::MOD_BITS] == '0)
		else $error("result padding not zero");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

endmodule

bind rsa_modular_exponentiation_top rme_checker u_rme_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

@@ test/rsa_modular_exponentiation_top_test.sv @@
`timescale 1ns / 1ps

module rsa_modular_exponentiation_top_test;

	class rsa_scoreboard;
		rme_pkg::word_t pending_q[$];
		rme_pkg::word_t modulus;
		rme_pkg::word_t pub_exp;
		rme_pkg::word_t priv_exp;
		int mismatches;
		int checked;

		function new();
			modulus = rme_pkg::word_t'(2);
			pub_exp = rme_pkg::word_t'(1);
			priv_exp = rme_pkg::word_t'(1);
			mismatches = 0;
			checked = 0;
		endfunction

		function void write_reg(logic [rme_pkg::CFG_IDX_W-1:0] idx, rme_pkg::word_t v);
			if (idx == rme_pkg::REG_MODULUS) begin
				modulus = v;
			end else if (idx == rme_pkg::REG_PUB_EXP) begin
				pub_exp = v;
			end else if (idx == rme_pkg::REG_PRIV_EXP) begin
				priv_exp = v;
			end
		endfunction

		function rme_pkg::word_t power_mod(longint unsigned base, rme_pkg::word_t e,
			rme_pkg::word_t m);
			longint unsigned acc;
			if (m < 2) begin
				return '0;
			end
			base = base % m;
			acc = 1;
			for (int i = rme_pkg::MOD_BITS - 1; i >= 0; i--) begin
				acc = (acc * acc) % m;
				if (e[i]) begin
					acc = (acc * base) % m;
				end
			end
			return rme_pkg::word_t'(acc);
		endfunction

		function void note_request(logic op, rme_pkg::word_t value);
			rme_pkg::word_t r;
			if (op == rme_pkg::OP_ENCRYPT) begin
				r = power_mod(64'(value[7:0]), pub_exp, modulus);
			end else begin
				r = power_mod(64'(value), priv_exp, modulus) & rme_pkg::word_t'(8'hff);
			end
			pending_q.push_back(r);
		endfunction

		function void check_result(rme_pkg::word_t got);
			rme_pkg::word_t want;
			checked++;
			if (pending_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("unexpected result %0d", got);
				end
				return;
			end
			want = pending_q.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("result mismatch: expected %0d actual %0d", want, got);
				end
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [rme_pkg::DATA_BITS-1:0] s_tdata = '0;
	logic s_tuser = 0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [rme_pkg::DATA_BITS-1:0] m_tdata;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [rme_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	rme_pkg::word_t cfg_data = '0;

	rsa_scoreboard sb = new();
	int cycles = 0;
	int hold_off = 0;
	int rx_wait = 0;
	int rx_draw = 0;
	int sent = 0;
	localparam int LIMIT = 3000000;

	rsa_modular_exponentiation_top dut (.*);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("rsa_modular_exponentiation_top_test: FAIL");
			$finish;
		end
	end

	// receiver with random waits per result and a long hold-off on request
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				sb.check_result(rme_pkg::word_t'(m_tdata));
			end
			if (hold_off > 0) begin
				hold_off <= hold_off - 1;
				m_tready <= 1'b0;
			end else if (m_tvalid && m_tready) begin
				rx_draw = $urandom_range(0, 12);
				rx_wait <= rx_draw;
				m_tready <= (rx_draw == 0);
			end else if (rx_wait > 0) begin
				rx_wait <= rx_wait - 1;
				m_tready <= (rx_wait == 1);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic cfg_write(logic [rme_pkg::CFG_IDX_W-1:0] idx, rme_pkg::word_t v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.write_reg(idx, v);
	endtask

	task automatic send(logic op, rme_pkg::word_t value, bit gaps);
		int gap;
		gap = gaps ? $urandom_range(0, 12) : 0;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
		end
		repeat (gap) @(posedge clk);
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= rme_pkg::DATA_BITS'(value);
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_request(op, value);
		sent++;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic setup(rme_pkg::word_t m, rme_pkg::word_t pe, rme_pkg::word_t de);
		cfg_write(rme_pkg::REG_MODULUS, m);
		cfg_write(rme_pkg::REG_PUB_EXP, pe);
		cfg_write(rme_pkg::REG_PRIV_EXP, de);
		cfg_valid <= 1'b0;
	endtask

	function automatic rme_pkg::word_t rand_word();
		return rme_pkg::word_t'({$urandom, $urandom});
	endfunction

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// reset register values
		send(rme_pkg::OP_ENCRYPT, 31'd5, 1'b0);
		send(rme_pkg::OP_DECRYPT, 31'd7, 1'b0);
		drain();
		// classic small key n = 3233, e = 17, d = 2753
		setup(31'd3233, 31'd17, 31'd2753);
		send(rme_pkg::OP_ENCRYPT, 31'd65, 1'b0);
		send(rme_pkg::OP_DECRYPT, 31'd2790, 1'b0);
		send(rme_pkg::OP_ENCRYPT, 31'd0, 1'b0);
		send(rme_pkg::OP_ENCRYPT, 31'd255, 1'b0);
		send(rme_pkg::OP_ENCRYPT, 31'h7fffff00, 1'b0);
		send(rme_pkg::OP_DECRYPT, 31'h7fffffff, 1'b0);
		send(rme_pkg::OP_DECRYPT, 31'd3233, 1'b0);
		send(rme_pkg::OP_DECRYPT, 31'd0, 1'b0);
		drain();
		// zero exponents and extreme registers
		setup(31'h7fffffff, 31'd0, 31'h7fffffff);
		send(rme_pkg::OP_ENCRYPT, 31'd200, 1'b0);
		send(rme_pkg::OP_DECRYPT, 31'h7ffffffe, 1'b0);
		send(rme_pkg::OP_DECRYPT, 31'h7fffffff, 1'b0);
		send(rme_pkg::OP_DECRYPT, 31'h55555555, 1'b0);
		drain();
		setup(31'd1, 31'h7fffffff, 31'd0);
		send(rme_pkg::OP_ENCRYPT, 31'd9, 1'b0);
		send(rme_pkg::OP_DECRYPT, 31'd9, 1'b0);
		drain();
		setup(31'd0, 31'd3, 31'd3);
		send(rme_pkg::OP_ENCRYPT, 31'd9, 1'b0);
		send(rme_pkg::OP_DECRYPT, 31'h2aaaaaaa, 1'b0);
		drain();
		// random phases; first one with long receiver hold-off
		for (int ph = 0; ph < 9; ph++) begin
			rme_pkg::word_t m;
			m = (ph % 3 == 0) ? rme_pkg::word_t'($urandom_range(2, 300)) : rand_word();
			if (m < 2) m = rme_pkg::word_t'(2);
			setup(m, (ph == 4) ? rme_pkg::word_t'(0) : rand_word(),
				(ph == 5) ? rme_pkg::word_t'(31'h7fffffff) : rand_word());
			if (ph == 0) begin
				hold_off = 3000;
			end
			for (int i = 0; i < 30; i++) begin
				send(1'($urandom_range(0, 1)), rand_word(), ph != 0);
			end
			drain();
		end
		$display("covered %0d requests over several key settings, incl. zero exponents,", sent);
		$display("degenerate moduli and a long output stall; %0d results checked", sb.checked);
		if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
			$display("rsa_modular_exponentiation_top_test: PASS");
		end else begin
			$display("rsa_modular_exponentiation_top_test: FAIL");
		end
		$finish;
	end
endmodule

@@ rsa_modular_exponentiation_top.f @@
hw/rtl/rme_pkg.sv
hw/rtl/rme_cell.sv
hw/rtl/rme_chain.sv
hw/rtl/rsa_modular_exponentiation_top.sv
hw/rtl/rme_checker.sv
test/rsa_modular_exponentiation_top_test.sv
